@@ rtl/dual_cpu_mailbox_fifo_defines.svh @@
// assertion macros for the dual processor mailbox
`ifndef DUAL_CPU_MAILBOX_FIFO_DEFINES_SVH
`define DUAL_CPU_MAILBOX_FIFO_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define DCMF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define DCMF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DCMF_ASSERT(label, prop, msg)
`define DCMF_ASSERT_NEVER(label, cond, msg)

`endif

`endif

@@ rtl/dcmf_pkg.sv @@
// types and constants shared by the mailbox modules
package dcmf_pkg;

  localparam int DCMF_QUEUE_DEPTH = 16;
  localparam int WORD_W           = 32;

  // access codes
  localparam logic [2:0] OP_POP      = 3'd0;
  localparam logic [2:0] OP_RD_CTRL  = 3'd1;
  localparam logic [2:0] OP_PUSH     = 3'd2;
  localparam logic [2:0] OP_WR_CTRL  = 3'd3;
  localparam logic [2:0] OP_RD_SYNC  = 3'd4;
  localparam logic [2:0] OP_WR_SYNC  = 3'd5;

  // configuration register indexes
  localparam logic CFG_MAIN_IRQ = 1'b0;
  localparam logic CFG_SUB_IRQ  = 1'b1;

  // control register bits
  localparam logic [7:0] CTRL_HI_RESET     = 8'h41;
  localparam int         CTRL_CLR_SEND_BIT = 3;
  localparam int         CTRL_CLR_RECV_BIT = 11;
  localparam int         SYNC_IRQ_BIT      = 13;

  // side indexes of the per-side registers
  localparam logic SIDE_MAIN = 1'b0;
  localparam logic SIDE_SUB  = 1'b1;

  typedef struct packed {
    logic [2:0]        opcode;
    logic              from_main;
    logic [WORD_W-1:0] write_data;
  } dcmf_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              push_dropped;
    logic              main_recv_irq;
    logic              main_send_irq;
    logic              sub_recv_irq;
    logic              sub_send_irq;
    logic              sub_sync_irq;
  } dcmf_out_t;

  // per-queue commands, already qualified against empty and full
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } dcmf_qctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dcmf_qstat_t;

endpackage

@@ rtl/dual_cpu_mailbox_fifo.sv @@
// top level of the dual processor mailbox with its two word queues
//
//  port group   dir  handshake             payload
//  in_*         in   in_valid / in_ready   dcmf_in_t  (opcode, from_main, write_data)
//  out_*        out  out_valid / out_ready dcmf_out_t (read_data, flags, irq pulses)
//  cfg_*        in   cfg_we                cfg_index, cfg_wdata
//
// an accepted transaction is held in the input register, is worked
// in a single pass against the queue heads and counts, and lands in the
// result register, which drives out_valid; one transaction per cycle is
// sustained while results are taken; the queue head read is registered
// and looks ahead to the pointer the current transaction leaves behind
// a stalled result holds the result register, and the input register holds
// behind it; in_ready drops only when both are full
// synchronous reset empties both queues, sets the control bytes to 0x41 and
// clears the sync nibbles and the irq attach bits
`include "dual_cpu_mailbox_fifo_defines.svh"

module dual_cpu_mailbox_fifo
  import dcmf_pkg::*;
#(
  parameter int QUEUE_DEPTH = DCMF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  // request channel
  input  logic      in_valid,
  output logic      in_ready,
  input  dcmf_in_t  in_data,
  // result channel
  output logic      out_valid,
  input  logic      out_ready,
  output dcmf_out_t out_data,
  // configuration writes
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic      cfg_wdata
);

  // input register
  dcmf_in_t s1_r;
  logic     s1_v_r;
  logic     s1_adv;

  // result register
  dcmf_out_t out_r;
  logic      out_v_r;
  dcmf_out_t res;

  // per-side registers, indexed main then sub
  logic [7:0] ctrl_hi_r [2];
  logic [3:0] sync_r [2];
  logic       main_conn_r;
  logic       sub_conn_r;

  // queue main-to-sub is main's send and sub's receive; sub-to-main the reverse
  dcmf_qctl_t        m2s_ctl, s2m_ctl;
  dcmf_qstat_t       m2s_stat, s2m_stat, m2s_stat_nxt, s2m_stat_nxt;
  logic [WORD_W-1:0] m2s_head, s2m_head;

  // views of the current transaction from the accessor's side
  logic              fm;
  logic              side;
  logic [WORD_W-1:0] wd;
  dcmf_qstat_t       send_stat, recv_stat;
  logic [WORD_W-1:0] recv_head;
  logic              do_push, do_pop, clr_send, clr_recv, trig;

  // a transaction moves on whenever the result register is free or draining
  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= in_data;
    end
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign fm        = s1_r.from_main;
  assign side      = fm ? SIDE_MAIN : SIDE_SUB;
  assign wd        = s1_r.write_data;
  assign send_stat = fm ? m2s_stat : s2m_stat;
  assign recv_stat = fm ? s2m_stat : m2s_stat;
  assign recv_head = fm ? s2m_head : m2s_head;

  assign do_push  = s1_adv && (s1_r.opcode == OP_PUSH) && !send_stat.full;
  assign do_pop   = s1_adv && (s1_r.opcode == OP_POP) && !recv_stat.empty;
  assign clr_send = s1_adv && (s1_r.opcode == OP_WR_CTRL) && wd[CTRL_CLR_SEND_BIT];
  assign clr_recv = s1_adv && (s1_r.opcode == OP_WR_CTRL) && wd[CTRL_CLR_RECV_BIT];

  always_comb begin
    m2s_ctl.push  = do_push && fm;
    m2s_ctl.pop   = do_pop && !fm;
    m2s_ctl.clear = fm ? clr_send : clr_recv;
    s2m_ctl.push  = do_push && !fm;
    s2m_ctl.pop   = do_pop && fm;
    s2m_ctl.clear = fm ? clr_recv : clr_send;
  end

  dcmf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_m2s (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (m2s_ctl),
    .wdata     (wd),
    .head_word (m2s_head),
    .stat      (m2s_stat),
    .stat_nxt  (m2s_stat_nxt)
  );

  dcmf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_s2m (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (s2m_ctl),
    .wdata     (wd),
    .head_word (s2m_head),
    .stat      (s2m_stat),
    .stat_nxt  (s2m_stat_nxt)
  );

  // single pass over the transaction in the input register
  always_comb begin
    res  = '0;
    trig = 1'b0;
    unique case (s1_r.opcode)
      OP_POP: begin
        if (!recv_stat.empty) begin
          res.read_data = recv_head;
          trig          = 1'b1;
        end
      end
      OP_RD_CTRL: begin
        // bit 14 reads as enabled; status replaces the low stored bits
        res.read_data = {16'h0, ctrl_hi_r[side][7], 1'b1, ctrl_hi_r[side][5:2],
                         recv_stat.full, recv_stat.empty, 6'h0,
                         send_stat.full, send_stat.empty};
      end
      OP_PUSH: begin
        if (send_stat.full) begin
          res.push_dropped = 1'b1;
        end else begin
          trig = 1'b1;
        end
      end
      OP_WR_CTRL: begin
        trig = 1'b1;
      end
      OP_RD_SYNC: begin
        // each side reads its partner's nibble
        res.read_data = {28'h0, sync_r[fm]};
      end
      OP_WR_SYNC: begin
        res.sub_sync_irq = fm && wd[SYNC_IRQ_BIT] && sub_conn_r;
        trig             = 1'b1;
      end
      default: begin
      end
    endcase
    // the queue irq pulses report the queue state after this transaction
    res.main_recv_irq = trig && main_conn_r && !s2m_stat_nxt.empty;
    res.main_send_irq = trig && main_conn_r && m2s_stat_nxt.empty;
    res.sub_recv_irq  = trig && sub_conn_r && !m2s_stat_nxt.empty;
    res.sub_send_irq  = trig && sub_conn_r && s2m_stat_nxt.empty;
  end

  // control bytes and sync nibbles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_hi_r[SIDE_MAIN] <= CTRL_HI_RESET;
      ctrl_hi_r[SIDE_SUB]  <= CTRL_HI_RESET;
      sync_r[SIDE_MAIN]    <= '0;
      sync_r[SIDE_SUB]     <= '0;
    end else if (s1_adv) begin
      if (s1_r.opcode == OP_WR_CTRL) begin
        ctrl_hi_r[side] <= wd[15:8];
      end
      if (s1_r.opcode == OP_WR_SYNC) begin
        sync_r[side] <= wd[3:0];
      end
    end
  end

  // irq controller attach bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_conn_r <= 1'b0;
      sub_conn_r  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MAIN_IRQ) begin
        main_conn_r <= cfg_wdata;
      end
      if (cfg_index == CFG_SUB_IRQ) begin
        sub_conn_r <= cfg_wdata;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // checks
  `DCMF_ASSERT_NEVER(a_push_into_full, (m2s_ctl.push && m2s_stat.full) || (s2m_ctl.push && s2m_stat.full), "push issued to a full queue")
  `DCMF_ASSERT_NEVER(a_pop_from_empty, (m2s_ctl.pop && m2s_stat.empty) || (s2m_ctl.pop && s2m_stat.empty), "pop issued to an empty queue")
  `DCMF_ASSERT_NEVER(a_sync_irq_from_sub, s1_adv && res.sub_sync_irq && !s1_r.from_main, "sync irq raised by a sub transaction")
  `DCMF_ASSERT(a_drop_is_quiet, (out_valid && out_data.push_dropped) |-> (out_data.read_data == '0 && !out_data.main_recv_irq && !out_data.sub_recv_irq), "dropped push carries data or irq")
  `DCMF_ASSERT(a_ready_when_empty, !s1_v_r |-> in_ready, "input stalled with an empty input register")

endmodule

@@ rtl/dcmf_queue.sv @@
// one direction of the mailbox: word storage, pointers and fill count
module dcmf_queue
  import dcmf_pkg::*;
#(
  parameter int DEPTH = DCMF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dcmf_qctl_t        ctl,
  input  logic [WORD_W-1:0] wdata,
  output logic [WORD_W-1:0] head_word,
  output dcmf_qstat_t       stat,
  output dcmf_qstat_t       stat_nxt
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] head_word_r;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
      cnt_nxt  = '0;
    end else begin
      if (ctl.pop) begin
        head_nxt = (head_r == LAST_PTR) ? '0 : head_r + PTR_W'(1);
        cnt_nxt  = cnt_r - CNT_W'(1);
      end
      if (ctl.push) begin
        tail_nxt = (tail_r == LAST_PTR) ? '0 : tail_r + PTR_W'(1);
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // registered read of the next head, bypassing a write to the same entry
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= wdata;
    end
    if (ctl.push && (tail_r == head_nxt)) begin
      head_word_r <= wdata;
    end else begin
      head_word_r <= mem[head_nxt];
    end
  end

  assign head_word      = head_word_r;
  assign stat.empty     = (cnt_r == '0);
  assign stat.full      = (cnt_r == FULL_CNT);
  assign stat_nxt.empty = (cnt_nxt == '0);
  assign stat_nxt.full  = (cnt_nxt == FULL_CNT);

endmodule
